FILE: hw/rtl/arvg_pkg.sv
// arvg_pkg: shared types, constants and helper functions of the arc ring vertex generator
// used by the divider cells, the rotation cells and the top level
`default_nettype none
package arvg_pkg;

	localparam int MAX_SEGMENTS_DEF = 1024;
	localparam int SEG_W = 11;
	localparam int SEG_REG_MAX = 2047;
	localparam int DVD_W = 30;
	localparam int Q_W = 16;
	localparam int XY_W = 18;
	localparam int Z_W = 16;
	localparam int CORDIC_STEPS = 15;
	localparam int PROD_W = 36;
	localparam logic signed [XY_W-1:0] CORDIC_START = 18'sd39797;

	// register indexes
	localparam logic [2:0] REG_WIDTH = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_THICK = 3'd2;
	localparam logic [2:0] REG_BEGIN = 3'd3;
	localparam logic [2:0] REG_END = 3'd4;
	localparam logic [2:0] REG_SEGS = 3'd5;
	localparam logic [2:0] REG_VIS = 3'd6;
	localparam logic [2:0] REG_ORIGIN = 3'd7;

	// atan(2^-k) in 1/65536 turn
	localparam logic [Z_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
		16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
		16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1
	};

	typedef struct packed {
		logic filled;
		logic vis;
		logic err;
	} side_t;

	typedef struct packed {
		logic [SEG_W-1:0] rem;
		logic [DVD_W-1:0] dvd;
		logic [Q_W-1:0]   q;
		logic             neg;
		side_t            side;
	} div_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic [1:0]             quad;
		side_t                  side;
	} cor_t;

	// center + round(p / 65536), ties away from zero, saturated to 18 bits
	function automatic logic [XY_W-1:0] coord(input logic [14:0] ctr,
		input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] r;
		logic signed [20:0] sr;
		logic signed [20:0] v;
		mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		r = (mag + PROD_W'(32768)) >> 16;
		sr = p[PROD_W-1] ? -$signed(r[20:0]) : $signed(r[20:0]);
		v = $signed({6'b0, ctr}) + sr;
		if (v > 21'sd131071) begin
			coord = 18'h1FFFF;
		end else if (v < -21'sd131072) begin
			coord = 18'h20000;
		end else begin
			coord = v[XY_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/arvg_div_cell.sv
// arvg_div_cell: one restoring division step, one quotient bit per cell
// depends on arvg_pkg
`default_nettype none
module arvg_div_cell
	import arvg_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [SEG_W-1:0] divisor,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire div_t             in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output div_t                  out_data
);

	logic       valid_q;
	div_t       data_q;
	logic [SEG_W:0] trial;
	logic       ge;
	div_t       nxt;

	// shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {in_data.rem, in_data.dvd[DVD_W-1]};
		ge = trial >= {1'b0, divisor};
		nxt = in_data;
		nxt.rem = ge ? SEG_W'(trial - {1'b0, divisor}) : trial[SEG_W-1:0];
		nxt.dvd = {in_data.dvd[DVD_W-2:0], 1'b0};
		nxt.q = {in_data.q[Q_W-2:0], ge};
	end

	assign in_ready = !valid_q || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// word register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule
`default_nettype wire

FILE: hw/rtl/arvg_cordic_cell.sv
// arvg_cordic_cell: one rotation-mode cordic step with a fixed shift
// depends on arvg_pkg
`default_nettype none
module arvg_cordic_cell
	import arvg_pkg::*;
#(
	parameter int K = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire cor_t in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output cor_t      out_data
);

	logic valid_q;
	cor_t data_q;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	cor_t nxt;

	// rotate toward zero residue, shifts floor toward minus infinity
	always_comb begin
		xs = in_data.x >>> K;
		ys = in_data.y >>> K;
		nxt = in_data;
		if (!in_data.z[Z_W-1]) begin
			nxt.x = in_data.x - ys;
			nxt.y = in_data.y + xs;
			nxt.z = in_data.z - $signed(ATAN_TURN[K]);
		end else begin
			nxt.x = in_data.x + ys;
			nxt.y = in_data.y - xs;
			nxt.z = in_data.z + $signed(ATAN_TURN[K]);
		end
	end

	assign in_ready = !valid_q || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// word register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule
`default_nettype wire

FILE: hw/rtl/arc_ring_vertex_generator.sv
// arc_ring_vertex_generator: top level, register port, multiply, divider and cordic chains
// depends on arvg_pkg, arvg_div_cell, arvg_cordic_cell
//
// Input channel s_*: one word per point index (tdata[10:0]). Output channel m_*: one
// word per index with the outer and inner vertex in tdata and the flags in tuser.
// Registers are to be written over the APB port only while the block is idle; the block
// itself does not enforce this. The path from acceptance to output valid runs through one
// multiply stage, 30 divider cells (one quotient bit each), 15 cordic cells, one product
// stage and the output register. Throughput is one word per cycle while the receiver accepts;
// every stage holds one word and passes it on when the next stage is empty or moving, so a
// stalled receiver first fills the empty stages and only then drops s_tready.
// Reset empties the pipeline and loads the register reset values (segment
// count 1, everything else 0). No clearing pass is needed after reset.
`default_nettype none
module arc_ring_vertex_generator
	import arvg_pkg::*;
#(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // point_index[10:0], zero pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // outer_x, outer_y, inner_x, inner_y (18 bits each)
	output logic [2:0]       m_tuser    // is_filled, is_visible, index_error
);

	localparam int CAP = (MAX_SEGMENTS > SEG_REG_MAX) ? SEG_REG_MAX : MAX_SEGMENTS;
	localparam logic [SEG_W-1:0] SEG_CAP = SEG_W'(CAP);

	// configuration registers
	logic [11:0]      width_q;
	logic [11:0]      height_q;
	logic [15:0]      thick_q;
	logic [17:0]      begin_q;
	logic [17:0]      end_q;
	logic [SEG_W-1:0] segs_q;
	logic [SEG_W-1:0] vis_q;
	logic             origin_q;
	logic             wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0;
			height_q <= '0;
			thick_q <= '0;
			begin_q <= '0;
			end_q <= '0;
			segs_q <= SEG_W'(1);
			vis_q <= '0;
			origin_q <= 1'b0;
		end else if (wr) begin
			unique case (paddr[4:2])
				REG_WIDTH: width_q <= pwdata[11:0];
				REG_HEIGHT: height_q <= pwdata[11:0];
				REG_THICK: thick_q <= pwdata[15:0];
				REG_BEGIN: begin_q <= pwdata[17:0];
				REG_END: end_q <= pwdata[17:0];
				REG_SEGS: segs_q <= pwdata[SEG_W-1:0];
				REG_VIS: vis_q <= pwdata[SEG_W-1:0];
				REG_ORIGIN: origin_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[4:2])
			REG_WIDTH: prdata = {20'b0, width_q};
			REG_HEIGHT: prdata = {20'b0, height_q};
			REG_THICK: prdata = {16'b0, thick_q};
			REG_BEGIN: prdata = {{14{begin_q[17]}}, begin_q};
			REG_END: prdata = {{14{end_q[17]}}, end_q};
			REG_SEGS: prdata = {21'b0, segs_q};
			REG_VIS: prdata = {21'b0, vis_q};
			REG_ORIGIN: prdata = {31'b0, origin_q};
			default: prdata = '0;
		endcase
	end

	// effective segment count
	logic [SEG_W-1:0] segs_eff;
	assign segs_eff = (segs_q == '0) ? SEG_W'(1) : ((segs_q > SEG_CAP) ? SEG_CAP : segs_q);

	// input flags and angle-span product
	logic [SEG_W-1:0]    idx;
	side_t               side_in;
	logic signed [18:0]  diff;
	logic signed [30:0]  prod;
	assign idx = s_tdata[SEG_W-1:0];
	assign side_in.err = idx > segs_eff;
	assign side_in.vis = !side_in.err && (idx <= vis_q);
	assign side_in.filled = thick_q > 16'd16;
	assign diff = $signed({end_q[17], end_q}) - $signed({begin_q[17], begin_q});
	assign prod = diff * $signed({1'b0, idx});

	// multiply stage
	logic               m_valid_q;
	logic               m_ready;
	logic signed [30:0] num_s1;
	side_t              side_s1;
	logic               d_ready [DVD_W+1];

	assign m_ready = !m_valid_q || d_ready[0];
	assign s_tready = m_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (m_ready) begin
			m_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && m_ready) begin
			num_s1 <= prod;
			side_s1 <= side_in;
		end
	end

	// divider chain, rounded quotient of |num| by the segment count
	logic [30:0] abs_num;
	div_t        d_data [DVD_W+1];
	logic        d_valid [DVD_W+1];

	assign abs_num = num_s1[30] ? 31'(-num_s1) : 31'(num_s1);
	assign d_valid[0] = m_valid_q;
	assign d_data[0].rem = '0;
	assign d_data[0].dvd = abs_num[DVD_W-1:0] + DVD_W'(segs_eff >> 1);
	assign d_data[0].q = '0;
	assign d_data[0].neg = num_s1[30];
	assign d_data[0].side = side_s1;

	for (genvar i = 0; i < DVD_W; i++) begin : g_div
		arvg_div_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.divisor(segs_eff),
			.in_valid(d_valid[i]),
			.in_ready(d_ready[i]),
			.in_data(d_data[i]),
			.out_valid(d_valid[i+1]),
			.out_ready(d_ready[i+1]),
			.out_data(d_data[i+1])
		);
	end

	// angle, fold to nearest quarter turn
	div_t            d_last;
	logic [15:0]     sq;
	logic [15:0]     ang;
	cor_t            c_data [CORDIC_STEPS+1];
	logic            c_valid [CORDIC_STEPS+1];
	logic            c_ready [CORDIC_STEPS+1];

	assign d_last = d_data[DVD_W];
	assign sq = d_last.neg ? 16'(-d_last.q) : d_last.q;
	assign ang = begin_q[15:0] + sq;
	assign c_valid[0] = d_valid[DVD_W];
	assign d_ready[DVD_W] = c_ready[0];
	assign c_data[0].x = CORDIC_START;
	assign c_data[0].y = '0;
	assign c_data[0].z = $signed({{2{ang[13]}}, ang[13:0]});
	assign c_data[0].quad = ang[15:14] + {1'b0, ang[13]};
	assign c_data[0].side = d_last.side;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		arvg_cordic_cell #(.K(k)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(c_valid[k]),
			.in_ready(c_ready[k]),
			.in_data(c_data[k]),
			.out_valid(c_valid[k+1]),
			.out_ready(c_ready[k+1]),
			.out_data(c_data[k+1])
		);
	end

	// quadrant map and radius products
	cor_t                    c_last;
	logic signed [XY_W-1:0]  cv;
	logic signed [XY_W-1:0]  sv;
	logic signed [XY_W-1:0]  rad;
	logic signed [XY_W-1:0]  inner;
	logic                    p_valid_q;
	logic                    p_ready;
	logic                    o_ready;
	logic signed [PROD_W-1:0] ox_s2, oy_s2, ix_s2, iy_s2;
	side_t                   side_s2;

	assign c_last = c_data[CORDIC_STEPS];
	always_comb begin
		case (c_last.quad)
			2'd0: begin cv = c_last.x; sv = c_last.y; end
			2'd1: begin cv = -c_last.y; sv = c_last.x; end
			2'd2: begin cv = -c_last.x; sv = -c_last.y; end
			default: begin cv = c_last.y; sv = -c_last.x; end
		endcase
	end
	assign rad = $signed({3'b0, width_q, 3'b0});
	assign inner = rad - $signed({2'b0, thick_q});

	assign p_ready = !p_valid_q || o_ready;
	assign c_ready[CORDIC_STEPS] = p_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_valid_q <= 1'b0;
		end else if (p_ready) begin
			p_valid_q <= c_valid[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (c_valid[CORDIC_STEPS] && p_ready) begin
			ox_s2 <= rad * cv;
			oy_s2 <= rad * sv;
			ix_s2 <= inner * cv;
			iy_s2 <= inner * sv;
			side_s2 <= c_last.side;
		end
	end

	// rounding, center offset and output register
	logic        o_valid_q;
	logic [14:0] cx;
	logic [14:0] cy;
	logic [71:0] tdata_q;
	side_t       side_q;

	assign cx = origin_q ? 15'd0 : {width_q, 3'b0};
	assign cy = origin_q ? 15'd0 : {height_q, 3'b0};
	assign o_ready = !o_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (o_ready) begin
			o_valid_q <= p_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (p_valid_q && o_ready) begin
			side_q <= side_s2;
			if (side_s2.err) begin
				tdata_q <= '0;
			end else begin
				tdata_q <= {coord(cy, iy_s2), coord(cx, ix_s2),
					coord(cy, oy_s2), coord(cx, ox_s2)};
			end
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata = tdata_q;
	assign m_tuser = {side_q.err, side_q.vis, side_q.filled};

	// an index error gives zero coordinates and is never visible
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> (m_tdata == '0) && !m_tuser[1])
		else $error("index error word carries coordinates or visibility");

	// an empty output register lets the whole chain move
	assert property (@(posedge clk) disable iff (!arst_n) !m_tvalid |-> s_tready)
		else $error("input stalled while output register empty");

	// the output register fills only from a valid product stage
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(!m_tvalid && !p_valid_q) |-> !m_tvalid)
		else $error("output valid without product stage");

endmodule
`default_nettype wire

FILE: verif/arvg_checker.sv
// arvg_checker: watches the point index and vertex streams and the register port of the
// arc ring vertex generator, predicts each vertex word and compares it; depends on arvg_pkg
`timescale 1ns / 1ps
`default_nettype none
module arvg_checker
	import arvg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [15:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [71:0] m_tdata,
	input  wire logic [2:0]  m_tuser,
	output int               fail_count,
	output int               pending,
	output int               vertex_count
);

	typedef struct packed {
		logic [17:0] ox;
		logic [17:0] oy;
		logic [17:0] ix;
		logic [17:0] iy;
		logic        filled;
		logic        vis;
		logic        err;
	} vertex_t;

	localparam int ATAN_TAB [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
		41, 20, 10, 5, 3, 1, 1};

	// shadow copy of the registers
	longint unsigned sh_width, sh_height, sh_thick, sh_segs, sh_vis, sh_origin;
	longint sh_begin, sh_end;
	vertex_t vertex_q[$];

	function automatic longint sx18(longint unsigned v);
		v &= 64'h3FFFF;
		return (v & 64'h20000) ? longint'(v) - 64'h40000 : longint'(v);
	endfunction

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rnd16(longint v);
		longint m, r;
		m = (v < 0) ? -v : v;
		r = (m + 32768) >> 16;
		return (v < 0) ? -r : r;
	endfunction

	function automatic logic [17:0] sat_coord(longint ctr, longint rad, longint trig);
		longint v;
		v = ctr + rnd16(rad * trig);
		if (v > 131071) v = 131071;
		if (v < -131072) v = -131072;
		return v[17:0];
	endfunction

	// vertex prediction for one point index
	function automatic vertex_t predict_vertex(logic [10:0] idx);
		vertex_t r;
		longint unsigned segs, mag;
		longint num, q, x, y, z, nx, ny, c, s, rad, inner, cx, cy;
		int quad;
		logic [15:0] a;
		segs = sh_segs;
		if (segs == 0) segs = 1;
		if (segs > MAX_SEGMENTS_DEF) segs = MAX_SEGMENTS_DEF;
		r = '0;
		r.err = idx > segs;
		r.filled = sh_thick > 16;
		r.vis = !r.err && idx <= sh_vis;
		if (r.err) return r;
		num = (sh_end - sh_begin) * longint'(idx);
		mag = (num < 0) ? -num : num;
		q = longint'((mag + segs / 2) / segs);
		if (num < 0) q = -q;
		a = 16'(sh_begin + q);
		quad = a[15:14];
		z = a[13:0];
		if (z >= 8192) begin
			z -= 16384;
			quad = (quad + 1) & 3;
		end
		x = 39797;
		y = 0;
		for (int k = 0; k < 15; k++) begin
			if (z >= 0) begin
				nx = x - shr_floor(y, k); ny = y + shr_floor(x, k); z -= ATAN_TAB[k];
			end else begin
				nx = x + shr_floor(y, k); ny = y - shr_floor(x, k); z += ATAN_TAB[k];
			end
			x = nx;
			y = ny;
		end
		case (quad)
			0: begin c = x; s = y; end
			1: begin c = -y; s = x; end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		rad = longint'(sh_width) * 8;
		inner = rad - longint'(sh_thick);
		cx = sh_origin ? 0 : longint'(sh_width) * 8;
		cy = sh_origin ? 0 : longint'(sh_height) * 8;
		r.ox = sat_coord(cx, rad, c);
		r.oy = sat_coord(cy, rad, s);
		r.ix = sat_coord(cx, inner, c);
		r.iy = sat_coord(cy, inner, s);
		return r;
	endfunction

	// compare one field
	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0h actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	assign pending = vertex_q.size();

	always @(posedge clk or negedge arst_n) begin
		vertex_t w;
		if (!arst_n) begin
			sh_width = 0; sh_height = 0; sh_thick = 0; sh_begin = 0; sh_end = 0;
			sh_segs = 1; sh_vis = 0; sh_origin = 0;
			vertex_q.delete();
			fail_count = 0;
			vertex_count = 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_WIDTH:  sh_width = pwdata[11:0];
					REG_HEIGHT: sh_height = pwdata[11:0];
					REG_THICK:  sh_thick = pwdata[15:0];
					REG_BEGIN:  sh_begin = sx18(pwdata);
					REG_END:    sh_end = sx18(pwdata);
					REG_SEGS:   sh_segs = pwdata[10:0];
					REG_VIS:    sh_vis = pwdata[10:0];
					default:    sh_origin = pwdata[0];
				endcase
			end
			// result word
			if (m_tvalid && m_tready) begin
				vertex_count++;
				if (vertex_q.size() == 0) begin
					$error("vertex word with no expectation waiting");
					fail_count++;
				end else begin
					w = vertex_q.pop_front();
					check_field("outer_x", w.ox, m_tdata[17:0]);
					check_field("outer_y", w.oy, m_tdata[35:18]);
					check_field("inner_x", w.ix, m_tdata[53:36]);
					check_field("inner_y", w.iy, m_tdata[71:54]);
					check_field("is_filled", w.filled, m_tuser[0]);
					check_field("is_visible", w.vis, m_tuser[1]);
					check_field("index_error", w.err, m_tuser[2]);
				end
			end
			// input word, appended at the tail of the expectation queue
			if (s_tvalid && s_tready)
				vertex_q = {vertex_q, predict_vertex(s_tdata[10:0])};
		end
	end

endmodule
`default_nettype wire

FILE: verif/tb_arc_ring_vertex_generator.sv
// tb_arc_ring_vertex_generator: stimulus and verdict for the arc ring vertex generator
// depends on arvg_pkg, arc_ring_vertex_generator and arvg_checker
`timescale 1ns / 1ps
`default_nettype none
module tb_arc_ring_vertex_generator
	import arvg_pkg::*;
();

	localparam int LATENCY = 48;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [2:0] m_tuser;
	int fail_count, pending, vertex_count;
	int send_idle = 7, recv_idle = 70;
	int cycles = 0;
	int configs = 0;

	always #5 clk = ~clk;

	arc_ring_vertex_generator u_top (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	arvg_checker u_chk (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending), .vertex_count(vertex_count)
	);

	// receiver stall, changed at the falling edge
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle);

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] ridx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {ridx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// send one point index, holding valid until accepted; valid stays up for the next word
	task automatic send_index(logic [10:0] idx);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic set_all(int w, int h, int th, int b, int e, int sg, int vc, int org);
		drain();
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_THICK, th);
		reg_write(REG_BEGIN, b);
		reg_write(REG_END, e);
		reg_write(REG_SEGS, sg);
		reg_write(REG_VIS, vc);
		reg_write(REG_ORIGIN, org);
		configs++;
	endtask

	// a random setting, small segment counts mostly, now and then an extreme
	task automatic random_setting();
		int sg;
		sg = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(64);
		set_all($urandom_range(4095), $urandom_range(4095),
			($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(40),
			$urandom, $urandom, sg, $urandom_range(2047), $urandom_range(1));
	endtask

	initial begin
		int segs;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		// reset values first, index zero and past the end
		send_index(11'd0);
		send_index(11'd1);
		send_index(11'd2);
		send_index(11'h7FF);
		// extremes: full width, full thickness, angles at the limits
		set_all(4095, 4095, 65535, 32'h20000, 32'h1FFFF, 1024, 1024, 0);
		send_index(11'd0); send_index(11'd512); send_index(11'd1024); send_index(11'd1025);
		set_all(4095, 0, 16, 0, 65536, 0, 0, 1);
		send_index(11'd0); send_index(11'd1); send_index(11'd2);
		set_all(100, 50, 17, -1000, 20000, 2047, 500, 0);
		send_index(11'd1024); send_index(11'd1025); send_index(11'd500); send_index(11'd501);
		set_all(0, 4095, 0, 16384, -16384, 8, 4, 1);
		for (int i = 0; i < 10; i++) send_index(11'(i));
		// random phases with the three idling patterns
		for (int ph = 0; ph < 30; ph++) begin
			if (ph == 10) begin send_idle = 70; recv_idle = 7; end
			else if (ph == 20) begin send_idle = 0; recv_idle = 0; end
			else if (ph == 0) begin send_idle = 7; recv_idle = 70; end
			random_setting();
			segs = int'(u_chk.sh_segs);
			if (segs == 0) segs = 1;
			if (segs > 1024) segs = 1024;
			for (int n = 0; n < 30; n++)
				send_index(11'(($urandom_range(15) == 0) ? $urandom_range(2047)
					: $urandom_range(segs)));
		end
		drain();
		$display("covered %0d register settings, %0d vertex words checked",
			configs, vertex_count);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire
